>>> rtl/sefr_pkg.sv
// package for the start/end frame receiver with additive checksum
// holds item structs, status codes and register indexes; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sefr_pkg;

    localparam int FRAME_LEN_DEF = 64;
    localparam int BYTE_W        = 8;
    localparam int BPOS_W        = 6;
    localparam int CFG_IDX_W     = 1;

    typedef enum logic [2:0] {
        ST_RECV     = 3'd0,
        ST_GOOD     = 3'd1,
        ST_SUM_BAD  = 3'd2,
        ST_END_BAD  = 3'd3,
        ST_STRAY    = 3'd4,
        ST_LINK_ERR = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_MARKER = 1'b0,
        CFG_END_MARKER   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              link_error;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] data_byte;
        logic [BPOS_W-1:0] byte_position;
        logic              byte_valid;
        logic              last_check_bad;
    } t_out_item;

endpackage

`default_nettype wire

>>> rtl/start_end_frame_receiver_sum_check_top.sv
// a result item is registered and appears in the cycle after its input item is accepted
// one item per cycle while output ready stays high, set by the single output register stage
// input ready follows output ready whenever a result is held
// reset (synchronous, active low) clears frame state, markers and sticky flag
// depends on sefr_pkg and sefr_core
`timescale 1ns / 1ps
`default_nettype none

module start_end_frame_receiver_sum_check_top
    import sefr_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BYTE_W-1:0]    i_cfg_data
);

    logic [BYTE_W-1:0] r_start_marker;
    logic [BYTE_W-1:0] r_end_marker;
    logic              r_out_valid;
    t_out_item         r_out;
    t_out_item         w_res;
    logic              w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= '0;
            r_end_marker   <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_START_MARKER: r_start_marker <= i_cfg_data;
                CFG_END_MARKER:   r_end_marker   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sefr_core #(
        .FRAME_LEN (FRAME_LEN)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_item         (i_in),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .o_res          (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_res;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sefr_core.sv
// frame tracking state and per-item result logic
// depends on sefr_pkg
`timescale 1ns / 1ps
`default_nettype none

module sefr_core
    import sefr_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire t_in_item          i_item,
    input  wire logic [BYTE_W-1:0] i_start_marker,
    input  wire logic [BYTE_W-1:0] i_end_marker,
    output t_out_item              o_res
);

    localparam int POS_W = $clog2(FRAME_LEN);
    localparam int EXT_W = (POS_W > BPOS_W) ? POS_W : BPOS_W;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] CHK_POS  = POS_W'(FRAME_LEN - 2);

    logic              r_in_frame, n_in_frame;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic              r_matched, n_matched;
    logic              r_check_bad, n_check_bad;
    logic [EXT_W-1:0]  w_pos_ext;
    logic              w_last;

    assign w_pos_ext = EXT_W'(r_pos);
    assign w_last    = (r_pos == LAST_POS);

    always_comb begin
        n_in_frame  = r_in_frame;
        n_pos       = r_pos;
        n_sum       = r_sum;
        n_matched   = r_matched;
        n_check_bad = r_check_bad;
        o_res       = '0;
        o_res.status = ST_RECV;
        if (i_item.link_error) begin
            n_in_frame   = 1'b0;
            n_pos        = '0;
            n_sum        = '0;
            n_matched    = 1'b0;
            o_res.status = ST_LINK_ERR;
        end else if (!r_in_frame) begin
            if (i_item.rx_byte != i_start_marker) begin
                n_pos        = '0;
                o_res.status = ST_STRAY;
            end else begin
                n_in_frame       = 1'b1;
                n_pos            = POS_W'(1);
                n_sum            = '0;
                n_matched        = 1'b0;
                o_res.data_byte  = i_item.rx_byte;
                o_res.byte_valid = 1'b1;
            end
        end else begin
            o_res.data_byte     = i_item.rx_byte;
            o_res.byte_valid    = 1'b1;
            o_res.byte_position = w_pos_ext[BPOS_W-1:0];
            if (w_last) begin
                if (i_item.rx_byte != i_end_marker) begin
                    o_res.status = ST_END_BAD;
                end else if (r_matched) begin
                    o_res.status = ST_GOOD;
                    n_check_bad  = 1'b0;
                end else begin
                    o_res.status = ST_SUM_BAD;
                    n_check_bad  = 1'b1;
                end
                n_in_frame = 1'b0;
                n_pos      = '0;
                n_sum      = '0;
                n_matched  = 1'b0;
            end else begin
                if (r_pos == CHK_POS) begin
                    n_matched = (i_item.rx_byte == r_sum);
                end else begin
                    n_sum = r_sum + i_item.rx_byte;
                end
                n_pos = r_pos + 1'b1;
            end
        end
        o_res.last_check_bad = n_check_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_pos       <= '0;
            r_sum       <= '0;
            r_matched   <= 1'b0;
            r_check_bad <= 1'b0;
        end else if (i_accept) begin
            r_in_frame  <= n_in_frame;
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_matched   <= n_matched;
            r_check_bad <= n_check_bad;
        end
    end

    a_idle_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_pos == '0))
        else $error("position nonzero while idle");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_POS)
        else $error("position past frame end");

    a_link_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.link_error) |=> (!r_in_frame && (r_sum == '0)))
        else $error("link error did not abort frame");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_in_frame && w_last) |=> !r_in_frame)
        else $error("frame stayed open after last item");

    a_flag_on_judge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_check_bad) |-> $past(i_accept && r_in_frame && w_last))
        else $error("sticky flag changed outside frame end");

endmodule

`default_nettype wire

>>> tb/tb_start_end_frame_receiver_sum_check_top.sv
// testbench for the start/end frame receiver: frames, noise and link errors go in
// through a queued driver, a monitor predicts each status item and checks the output
// depends on sefr_pkg and start_end_frame_receiver_sum_check_top
`timescale 1ns / 1ps

module tb_start_end_frame_receiver_sum_check_top;
    import sefr_pkg::*;

    localparam int FRAME_LEN = FRAME_LEN_DEF;

    typedef enum int {FR_GOOD, FR_SUM_BAD, FR_END_BAD, FR_ABORT} t_frame_kind;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_item             in_item   = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data  = '0;
    logic                 in_ready;
    logic                 out_valid;
    logic                 cfg_ready;
    t_out_item            out_item;

    t_in_item  tx_bytes[$];
    t_out_item expected_results[$];
    logic      calm = 1'b0;
    int        fail_count = 0;
    int        items_queued = 0;
    int        results_seen = 0;
    int        status_count [0:5] = '{default: 0};

    // receiver copy: markers, frame state and sticky flag
    logic [7:0] start_mk = '0;
    logic [7:0] end_mk   = '0;
    logic       in_frame = 1'b0;
    logic [8:0] next_pos = '0;
    logic [7:0] run_sum  = '0;
    logic       sum_ok   = 1'b0;
    logic       chk_bad  = 1'b0;

    start_end_frame_receiver_sum_check_top #(
        .FRAME_LEN(FRAME_LEN)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic t_out_item frame_rx_predict(t_in_item it);
        t_out_item r;
        r = '0;
        r.status = ST_RECV;
        if (it.link_error) begin
            in_frame = 1'b0;
            next_pos = '0;
            run_sum  = '0;
            sum_ok   = 1'b0;
            r.status = ST_LINK_ERR;
        end else if (!in_frame) begin
            if (it.rx_byte != start_mk) begin
                next_pos = '0;
                r.status = ST_STRAY;
            end else begin
                in_frame = 1'b1;
                next_pos = 9'd1;
                run_sum  = '0;
                sum_ok   = 1'b0;
                r.data_byte  = it.rx_byte;
                r.byte_valid = 1'b1;
            end
        end else begin
            r.data_byte     = it.rx_byte;
            r.byte_valid    = 1'b1;
            r.byte_position = next_pos[BPOS_W-1:0];
            if (next_pos + 1 >= FRAME_LEN) begin
                if (it.rx_byte != end_mk) begin
                    r.status = ST_END_BAD;
                end else if (sum_ok) begin
                    r.status = ST_GOOD;
                    chk_bad  = 1'b0;
                end else begin
                    r.status = ST_SUM_BAD;
                    chk_bad  = 1'b1;
                end
                in_frame = 1'b0;
                next_pos = '0;
                run_sum  = '0;
                sum_ok   = 1'b0;
            end else begin
                if (next_pos + 2 == FRAME_LEN) begin
                    sum_ok = (it.rx_byte == run_sum);
                end else begin
                    run_sum = run_sum + it.rx_byte;
                end
                next_pos = next_pos + 1;
            end
        end
        r.last_check_bad = chk_bad;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (tx_bytes.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
                in_valid <= 1'b1;
                in_item  <= tx_bytes.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_results.push_back(frame_rx_predict(in_item));
            end
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result item, status %0d", out_item.status);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    status_count[want.status]++;
                    check_field("status", want.status, out_item.status);
                    check_field("data_byte", want.data_byte, out_item.data_byte);
                    check_field("byte_position", want.byte_position, out_item.byte_position);
                    check_field("byte_valid", want.byte_valid, out_item.byte_valid);
                    check_field("last_check_bad", want.last_check_bad,
                                out_item.last_check_bad);
                end
            end
            out_ready <= calm || ($urandom_range(99) >= 8);
        end
    end

    task automatic set_marker(t_cfg_idx idx, logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_START_MARKER) begin
            start_mk = val;
        end else begin
            end_mk = val;
        end
    endtask

    task automatic queue_byte(logic [7:0] b, logic le);
        t_in_item it;
        it.rx_byte    = b;
        it.link_error = le;
        tx_bytes.push_back(it);
        items_queued++;
    endtask

    function automatic logic [7:0] body_byte();
        int r;
        r = $urandom_range(7);
        case (r)
            0: return start_mk;
            1: return end_mk;
            2: return $urandom_range(1) ? 8'h00 : 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_frame(t_frame_kind kind, int abort_at);
        logic [7:0] body_sum;
        logic [7:0] b;
        body_sum = '0;
        for (int i = 0; i < FRAME_LEN; i++) begin
            if (kind == FR_ABORT && i == abort_at) begin
                queue_byte(8'($urandom), 1'b1);
                return;
            end
            if (i == 0) begin
                b = start_mk;
            end else if (i == FRAME_LEN - 2) begin
                if (kind == FR_SUM_BAD) begin
                    b = body_sum + 8'($urandom_range(1, 255));
                end else if (kind == FR_END_BAD && $urandom_range(1)) begin
                    b = 8'($urandom);
                end else begin
                    b = body_sum;
                end
            end else if (i == FRAME_LEN - 1) begin
                b = (kind == FR_END_BAD) ? end_mk ^ 8'($urandom_range(1, 255)) : end_mk;
            end else begin
                b = body_byte();
                body_sum = body_sum + b;
            end
            queue_byte(b, 1'b0);
        end
    endtask

    task automatic queue_noise();
        logic [7:0] b;
        logic       le;
        if ($urandom_range(19) == 0) begin
            // broken sequence: frame opened and cut by a link error
            queue_byte(start_mk, 1'b0);
            queue_byte(8'($urandom), 1'b1);
        end else begin
            b  = 8'($urandom);
            le = ($urandom_range(99) < 30);
            if (!le && b == start_mk) begin
                b = ~b;
            end
            queue_byte(b, le);
        end
    endtask

    task automatic queue_random_traffic(int count);
        int target;
        int r;
        target = items_queued + count;
        while (items_queued < target) begin
            if ($urandom_range(99) < 25) begin
                repeat ($urandom_range(1, 3)) queue_noise();
            end
            r = $urandom_range(99);
            if (r < 55) begin
                queue_frame(FR_GOOD, 0);
            end else if (r < 70) begin
                queue_frame(FR_SUM_BAD, 0);
            end else if (r < 85) begin
                queue_frame(FR_END_BAD, 0);
            end else begin
                queue_frame(FR_ABORT, $urandom_range(0, FRAME_LEN - 1));
            end
        end
    endtask

    // every queued item has produced its result item
    task automatic wait_all_done();
        do @(posedge clk); while (results_seen < items_queued);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        #400_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        set_marker(CFG_START_MARKER, 8'h00);
        set_marker(CFG_END_MARKER, 8'hFF);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_frame(FR_GOOD, 0);
        queue_frame(FR_SUM_BAD, 0);
        queue_frame(FR_END_BAD, 0);
        queue_frame(FR_GOOD, 0);
        queue_frame(FR_ABORT, FRAME_LEN - 1);
        wait_all_done();

        set_marker(CFG_START_MARKER, 8'hFF);
        set_marker(CFG_END_MARKER, 8'h00);
        queue_random_traffic(500);
        wait_all_done();

        // no idling on either side
        set_marker(CFG_START_MARKER, 8'h7E);
        set_marker(CFG_END_MARKER, 8'h7E);
        calm = 1'b1;
        queue_random_traffic(450);
        wait_all_done();
        calm = 1'b0;

        set_marker(CFG_START_MARKER, 8'($urandom));
        set_marker(CFG_END_MARKER, 8'($urandom));
        queue_random_traffic(500);
        wait_all_done();

        $display("ran %0d bytes: %0d good, %0d checksum bad, %0d end mismatch frames",
                 items_queued, status_count[ST_GOOD], status_count[ST_SUM_BAD],
                 status_count[ST_END_BAD]);
        $display("%0d stray bytes, %0d link errors, markers at both extremes and equal",
                 status_count[ST_STRAY], status_count[ST_LINK_ERR]);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/sefr_pkg.sv
rtl/sefr_core.sv
rtl/start_end_frame_receiver_sum_check_top.sv
tb/tb_start_end_frame_receiver_sum_check_top.sv
